// ===== rtl/rdcc_pkg.sv =====
package rdcc_pkg;

  // Field widths
  localparam int PIXEL_W       = 16;
  localparam int CHAN_W        = 6;
  localparam int SUM_W         = 16;
  localparam int MARGIN_W      = 16;
  localparam int PIXEL_COUNT_W = 11;
  localparam int CFG_DATA_W    = 16;
  localparam int CFG_INDEX_W   = 1;

  // Defaults
  localparam int DEFAULT_MAX_PIXELS = 1024;
  localparam logic [PIXEL_COUNT_W-1:0] PIXEL_COUNT_RESET = PIXEL_COUNT_W'(300);

  // Configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] CFG_COLOR_MARGIN = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] CFG_PIXEL_COUNT  = 1'b1;

  // Dominant color codes
  typedef enum logic [1:0] {
    CLASS_BLACK = 2'd0,
    CLASS_RED   = 2'd1,
    CLASS_GREEN = 2'd2,
    CLASS_BLUE  = 2'd3
  } color_class_t;

  // Channel sums of one completed frame
  typedef struct packed {
    logic [SUM_W-1:0] red;
    logic [SUM_W-1:0] green;
    logic [SUM_W-1:0] blue;
  } totals_t;

endpackage

// ===== rtl/rdcc_result_stage.sv =====
module rdcc_result_stage (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           tot_valid,
  output logic                           tot_ready,
  input  rdcc_pkg::totals_t              tot,
  input  logic [rdcc_pkg::MARGIN_W-1:0]  margin,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [1:0]                     color_class,
  output logic [rdcc_pkg::SUM_W-1:0]     red_total,
  output logic [rdcc_pkg::SUM_W-1:0]     green_total,
  output logic [rdcc_pkg::SUM_W-1:0]     blue_total
);
  import rdcc_pkg::*;

  logic [SUM_W:0]  r_ext;
  logic [SUM_W:0]  g_ext;
  logic [SUM_W:0]  b_ext;
  logic [SUM_W:0]  r_plus_m;
  logic [SUM_W:0]  g_plus_m;
  logic [SUM_W:0]  b_plus_m;
  color_class_t    class_next;
  color_class_t    class_reg;

  // Widen by one bit so adding the margin cannot wrap
  assign r_ext    = {1'b0, tot.red};
  assign g_ext    = {1'b0, tot.green};
  assign b_ext    = {1'b0, tot.blue};
  assign r_plus_m = r_ext + {1'b0, margin};
  assign g_plus_m = g_ext + {1'b0, margin};
  assign b_plus_m = b_ext + {1'b0, margin};

  // Pick the channel that beats both others by more than the margin
  always_comb begin
    if (r_ext > b_plus_m && r_ext > g_plus_m) begin
      class_next = CLASS_RED;
    end else if (g_ext > r_plus_m && g_ext > b_plus_m) begin
      class_next = CLASS_GREEN;
    end else if (b_ext > r_plus_m && b_ext > g_plus_m) begin
      class_next = CLASS_BLUE;
    end else begin
      class_next = CLASS_BLACK;
    end
  end

  // Output register takes a new result when empty or being transferred
  assign tot_ready = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (tot_ready) begin
      out_valid <= tot_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (tot_ready && tot_valid) begin
      class_reg   <= class_next;
      red_total   <= tot.red;
      green_total <= tot.green;
      blue_total  <= tot.blue;
    end
  end

  assign color_class = class_reg;

  // A red or green class always holds the largest sum
  a_red_largest: assert property (@(posedge clk) disable iff (rst)
    out_valid && class_reg == CLASS_RED |-> red_total > green_total && red_total > blue_total)
    else $error("red class without largest red sum");

  a_green_largest: assert property (@(posedge clk) disable iff (rst)
    out_valid && class_reg == CLASS_GREEN |->
      green_total > red_total && green_total > blue_total)
    else $error("green class without largest green sum");

  // Hold a stalled result unchanged
  a_hold_stalled: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=>
      out_valid && $stable(class_reg) && $stable(red_total) &&
      $stable(green_total) && $stable(blue_total))
    else $error("stalled result changed");

endmodule

// ===== rtl/rgb565_dominant_color_classifier.sv =====
// RGB565 dominant color classifier.
//
// Pixels enter on in_valid/in_stall with pixel_word; one transfer is one
// pixel. Red and blue 5-bit fields are doubled to 6 bits, green is used as
// is, and the three values are added into saturating 16-bit sums. When the
// frame length (pixel_count, 0 treated as 1, clamped to MAX_PIXELS) is
// reached, one result leaves on out_valid/out_stall with the three sums and
// color_class (0 black, 1 red, 2 green, 3 blue); the sums then clear.
//
// Throughput: one pixel per cycle while in_stall is low, set by the accumulate stage.
// The closing pixel of a frame passes the input register, the frame totals
// register and the output register before its result is presented.
// When the receiver stalls, the output register and the totals register
// hold up to two results; pixels that do not close a frame keep flowing,
// and in_stall rises only when a frame would close with no room left.
// Configuration: cfg_write with cfg_index 0 (dominance margin) or 1
// (pixel_count), written while the block is idle.
// Reset (rst, synchronous): empties all stages, clears sums and the pixel
// counter, sets the dominance margin to 0 and pixel_count to 300.
module rgb565_dominant_color_classifier #(
  parameter int MAX_PIXELS = rdcc_pkg::DEFAULT_MAX_PIXELS
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_write,
  input  logic [rdcc_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [rdcc_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [rdcc_pkg::PIXEL_W-1:0]     pixel_word,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [1:0]                       color_class,
  output logic [rdcc_pkg::SUM_W-1:0]       red_total,
  output logic [rdcc_pkg::SUM_W-1:0]       green_total,
  output logic [rdcc_pkg::SUM_W-1:0]       blue_total
);
  import rdcc_pkg::*;

  localparam int CNT_W = $clog2(MAX_PIXELS);
  localparam int LEN_W = $clog2(MAX_PIXELS + 1);
  localparam int CMP_W = (LEN_W > PIXEL_COUNT_W) ? LEN_W : PIXEL_COUNT_W;

  // Configuration registers
  logic [MARGIN_W-1:0]      dom_margin;
  logic [PIXEL_COUNT_W-1:0] pixel_count;

  // Input register
  logic                     s1_valid;
  logic [PIXEL_W-1:0]       s1_word;

  // Frame state
  logic [SUM_W-1:0]         red_acc;
  logic [SUM_W-1:0]         green_acc;
  logic [SUM_W-1:0]         blue_acc;
  logic [CNT_W-1:0]         seen;

  // Frame totals register
  logic                     s2_valid;
  totals_t                  s2_tot;
  logic                     s2_ready;
  logic                     s2_free;

  logic [CHAN_W-1:0]        r6;
  logic [CHAN_W-1:0]        g6;
  logic [CHAN_W-1:0]        b6;
  logic [SUM_W:0]           red_sum;
  logic [SUM_W:0]           green_sum;
  logic [SUM_W:0]           blue_sum;
  totals_t                  sums_next;
  logic [CMP_W-1:0]         pc_ext;
  logic [CMP_W-1:0]         frame_len;
  logic [CMP_W-1:0]         seen_inc;
  logic                     s1_done;
  logic                     s1_fire;

  // Decode configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      dom_margin  <= '0;
      pixel_count <= PIXEL_COUNT_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_COLOR_MARGIN: dom_margin  <= cfg_data[MARGIN_W-1:0];
        CFG_PIXEL_COUNT:  pixel_count <= cfg_data[PIXEL_COUNT_W-1:0];
        default:          dom_margin  <= dom_margin;
      endcase
    end
  end

  // Clamp the frame length to one through MAX_PIXELS
  assign pc_ext = CMP_W'(pixel_count);
  always_comb begin
    if (pc_ext == '0) begin
      frame_len = CMP_W'(1);
    end else if (pc_ext > CMP_W'(MAX_PIXELS)) begin
      frame_len = CMP_W'(MAX_PIXELS);
    end else begin
      frame_len = pc_ext;
    end
  end

  // Unpack the pixel and add into saturating sums
  assign r6        = {s1_word[15:11], 1'b0};
  assign g6        = s1_word[10:5];
  assign b6        = {s1_word[4:0], 1'b0};
  assign red_sum   = {1'b0, red_acc} + (SUM_W+1)'(r6);
  assign green_sum = {1'b0, green_acc} + (SUM_W+1)'(g6);
  assign blue_sum  = {1'b0, blue_acc} + (SUM_W+1)'(b6);

  assign sums_next.red   = red_sum[SUM_W]   ? '1 : red_sum[SUM_W-1:0];
  assign sums_next.green = green_sum[SUM_W] ? '1 : green_sum[SUM_W-1:0];
  assign sums_next.blue  = blue_sum[SUM_W]  ? '1 : blue_sum[SUM_W-1:0];

  assign seen_inc = CMP_W'(seen) + CMP_W'(1);
  assign s1_done  = seen_inc >= frame_len;

  // A closing pixel needs room in the totals register; others always advance
  assign s2_free  = !s2_valid || s2_ready;
  assign s1_fire  = s1_valid && (!s1_done || s2_free);
  assign in_stall = s1_valid && !s1_fire;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!in_stall) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      s1_word <= pixel_word;
    end
  end

  // Advance the running sums; clear them when the frame closes
  always_ff @(posedge clk) begin
    if (rst) begin
      red_acc   <= '0;
      green_acc <= '0;
      blue_acc  <= '0;
      seen      <= '0;
    end else if (s1_fire) begin
      if (s1_done) begin
        red_acc   <= '0;
        green_acc <= '0;
        blue_acc  <= '0;
        seen      <= '0;
      end else begin
        red_acc   <= sums_next.red;
        green_acc <= sums_next.green;
        blue_acc  <= sums_next.blue;
        seen      <= seen_inc[CNT_W-1:0];
      end
    end
  end

  // Frame totals register
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (s1_fire && s1_done) begin
      s2_valid <= 1'b1;
    end else if (s2_ready) begin
      s2_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && s1_done) begin
      s2_tot <= sums_next;
    end
  end

  // Classify and hold the result for the receiver
  rdcc_result_stage u_result (
    .clk         (clk),
    .rst         (rst),
    .tot_valid   (s2_valid),
    .tot_ready   (s2_ready),
    .tot         (s2_tot),
    .margin      (dom_margin),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .color_class (color_class),
    .red_total   (red_total),
    .green_total (green_total),
    .blue_total  (blue_total)
  );

  // A closing pixel always lands in the totals register
  a_close_loads: assert property (@(posedge clk) disable iff (rst)
    s1_fire && s1_done |=> s2_valid)
    else $error("frame closed without loading totals");

  // Sums and counter restart after a frame closes
  a_close_clears: assert property (@(posedge clk) disable iff (rst)
    s1_fire && s1_done |=> seen == '0 && red_acc == '0 && green_acc == '0 && blue_acc == '0)
    else $error("frame state not cleared after close");

  // Within a frame, sums never decrease
  a_sums_grow: assert property (@(posedge clk) disable iff (rst)
    s1_fire && !s1_done |=>
      red_acc >= $past(red_acc) && green_acc >= $past(green_acc) &&
      blue_acc >= $past(blue_acc))
    else $error("running sum decreased within a frame");

endmodule

// ===== tb/sv/tb.sv =====
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import rdcc_pkg::*;

  localparam int FRAME_MAX     = DEFAULT_MAX_PIXELS;
  localparam int STUCK_LIMIT   = 2000;
  localparam int SETTLE_CYCLES = 4;
  localparam int PIXEL_BUDGET  = 1600;
  localparam int PRINT_CAP     = 40;

  typedef enum int {TINT_NONE, TINT_RED, TINT_GREEN, TINT_BLUE, TINT_GRAY} tint_t;

  typedef struct {
    color_class_t cls;
    totals_t      sums;
  } frame_result_t;

  logic                     clk         = 1'b0;
  logic                     rst         = 1'b1;
  logic                     cfg_write   = 1'b0;
  logic [CFG_INDEX_W-1:0]   cfg_index   = CFG_COLOR_MARGIN;
  logic [CFG_DATA_W-1:0]    cfg_data    = '0;
  logic                     in_valid    = 1'b0;
  logic                     in_stall;
  logic [PIXEL_W-1:0]       pixel_word  = '0;
  logic                     out_valid;
  logic                     out_stall   = 1'b0;
  logic [1:0]               color_class;
  logic [SUM_W-1:0]         red_total;
  logic [SUM_W-1:0]         green_total;
  logic [SUM_W-1:0]         blue_total;

  // Shadow of the block's registers and frame state
  logic [MARGIN_W-1:0]      margin_shadow    = '0;
  logic [PIXEL_COUNT_W-1:0] frame_len_shadow = PIXEL_COUNT_RESET;
  totals_t                  running_sums     = '0;
  int unsigned              frame_fill       = 0;

  frame_result_t            expected_frames[$];
  logic [PIXEL_W-1:0]       pixel_q[$];

  int  errors         = 0;
  int  pixels_taken   = 0;
  int  frames_checked = 0;
  int  class_seen[4]  = '{0, 0, 0, 0};
  bit  pix_xfer       = 1'b0;
  bit  pace_on        = 1'b0;
  bit  stall_on       = 1'b0;
  int  gap_left       = 0;
  int  hold_left      = 0;

  rgb565_dominant_color_classifier dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_write   (cfg_write),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .pixel_word  (pixel_word),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .color_class (color_class),
    .red_total   (red_total),
    .green_total (green_total),
    .blue_total  (blue_total)
  );

  // Run the clock
  initial begin
    forever #2 clk = ~clk;
  end

  // Add a channel value into a sum, saturating at full scale
  function automatic logic [SUM_W-1:0] sat_sum(logic [SUM_W-1:0] acc, logic [CHAN_W-1:0] v);
    logic [SUM_W:0] s;
    s = {1'b0, acc} + (SUM_W+1)'(v);
    return s[SUM_W] ? '1 : s[SUM_W-1:0];
  endfunction

  // Pick the dominant channel; one extra bit keeps sum plus margin from wrapping
  function automatic color_class_t dominant_class(totals_t t, logic [MARGIN_W-1:0] m);
    logic [SUM_W:0] r, g, b, mw;
    r  = {1'b0, t.red};
    g  = {1'b0, t.green};
    b  = {1'b0, t.blue};
    mw = {1'b0, m};
    if (r > b + mw && r > g + mw) return CLASS_RED;
    if (g > r + mw && g > b + mw) return CLASS_GREEN;
    if (b > r + mw && b > g + mw) return CLASS_BLUE;
    return CLASS_BLACK;
  endfunction

  // Frame length in force: zero acts as one, clamp to the block's maximum
  function automatic int unsigned frame_target();
    if (frame_len_shadow == 0) return 1;
    if (frame_len_shadow > FRAME_MAX) return FRAME_MAX;
    return 32'(frame_len_shadow);
  endfunction

  // Accumulate one accepted pixel; queue the frame result when the frame closes
  task automatic absorb_pixel(logic [PIXEL_W-1:0] w);
    frame_result_t fr;
    running_sums.red   = sat_sum(running_sums.red,   {w[15:11], 1'b0});
    running_sums.green = sat_sum(running_sums.green, w[10:5]);
    running_sums.blue  = sat_sum(running_sums.blue,  {w[4:0], 1'b0});
    frame_fill++;
    if (frame_fill >= frame_target()) begin
      fr.cls  = dominant_class(running_sums, margin_shadow);
      fr.sums = running_sums;
      expected_frames.push_back(fr);
      running_sums = '0;
      frame_fill   = 0;
    end
  endtask

  task automatic flag_mismatch(string msg);
    errors++;
    if (errors <= PRINT_CAP) $display("[%0t] mismatch: %s", $time, msg);
  endtask

  // Idle length: mostly none, often short, now and then long
  function automatic int idle_len();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [PIXEL_W-1:0] tinted_pixel(tint_t tint);
    logic [4:0] r, b;
    logic [5:0] g;
    r = 5'($urandom);
    g = 6'($urandom);
    b = 5'($urandom);
    case (tint)
      TINT_RED: begin
        r = 5'($urandom_range(20, 31));
        g = 6'($urandom_range(0, 40));
        b = 5'($urandom_range(0, 20));
      end
      TINT_GREEN: begin
        r = 5'($urandom_range(0, 20));
        g = 6'($urandom_range(32, 63));
        b = 5'($urandom_range(0, 20));
      end
      TINT_BLUE: begin
        r = 5'($urandom_range(0, 20));
        g = 6'($urandom_range(0, 40));
        b = 5'($urandom_range(20, 31));
      end
      TINT_GRAY: begin
        g = {r, 1'($urandom_range(0, 1))};
        b = r;
      end
      default: ;
    endcase
    return {r, g, b};
  endfunction

  // Wait until every queued pixel is in and every frame result is out
  task automatic settle();
    do @(negedge clk);
    while (pixel_q.size() != 0 || in_valid || expected_frames.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Write one register; the block is idle, so the shadow updates at once
  task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    if (idx == CFG_COLOR_MARGIN) margin_shadow = val;
    else frame_len_shadow = val[PIXEL_COUNT_W-1:0];
    @(negedge clk);
    cfg_write <= 1'b0;
  endtask

  // Pixel driver: advance on transfer, insert random gaps
  always @(negedge clk) begin
    if (!in_valid || pix_xfer) begin
      if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (pixel_q.size() > 0) begin
        pixel_word <= pixel_q.pop_front();
        in_valid   <= 1'b1;
        gap_left   = pace_on ? idle_len() : 0;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Result receiver: stall in random stretches
  always @(negedge clk) begin
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      hold_left = (stall_on && $urandom_range(0, 3) == 0) ? idle_len() : 0;
      out_stall <= (hold_left > 0);
      if (hold_left > 0) hold_left--;
    end
  end

  // Monitor: predict on each pixel transfer, check each result transfer
  always @(posedge clk) begin : monitor
    frame_result_t want;
    pix_xfer = !rst && in_valid && !in_stall;
    if (pix_xfer) begin
      absorb_pixel(pixel_word);
      pixels_taken++;
    end
    if (!rst && out_valid && !out_stall) begin
      if (expected_frames.size() == 0) begin
        flag_mismatch($sformatf("result with no frame pending: class %0d sums %0d/%0d/%0d",
                                color_class, red_total, green_total, blue_total));
      end else begin
        want = expected_frames.pop_front();
        frames_checked++;
        class_seen[want.cls]++;
        if (color_class !== want.cls)
          flag_mismatch($sformatf("color_class %0d, want %0d", color_class, want.cls));
        if (red_total !== want.sums.red)
          flag_mismatch($sformatf("red_total %0d, want %0d", red_total, want.sums.red));
        if (green_total !== want.sums.green)
          flag_mismatch($sformatf("green_total %0d, want %0d", green_total, want.sums.green));
        if (blue_total !== want.sums.blue)
          flag_mismatch($sformatf("blue_total %0d, want %0d", blue_total, want.sums.blue));
      end
    end
  end

  // Watchdog: end the run when nothing moves for too long
  initial begin : watchdog
    int stuck;
    stuck = 0;
    while (stuck < STUCK_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) stuck = 0;
      else stuck++;
    end
    $display("watchdog: %0d cycles without a transfer", STUCK_LIMIT);
    $display("tb: errors");
    $finish;
  end

  // Stimulus
  initial begin : stimulus
    int                       planned;
    int                       phase;
    int                       n;
    int                       span;
    int                       roll;
    tint_t                    tint;
    logic [PIXEL_COUNT_W-1:0] len;
    logic [MARGIN_W-1:0]      marg;
    logic [4:0]               junk;

    planned = 0;
    phase   = 0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Reset settings: three extreme pixels must not close a 300-pixel frame
    pixel_q.push_back(16'h0000);
    pixel_q.push_back(16'hFFFF);
    pixel_q.push_back(16'hF800);
    settle();
    // Shrink the frame below the pixels already taken: the next pixel closes it
    write_reg(CFG_PIXEL_COUNT, 16'd1);
    pixel_q.push_back(16'h07E0);
    settle();

    // Single-pixel frames: pure channels, black, near-tie and exact tie
    pixel_q.push_back(16'hF800);
    pixel_q.push_back(16'h07E0);
    pixel_q.push_back(16'h001F);
    pixel_q.push_back(16'h0000);
    pixel_q.push_back(16'hFFFF);
    pixel_q.push_back(16'h0821);
    settle();

    // Zero frame length acts as one
    write_reg(CFG_PIXEL_COUNT, 16'd0);
    pixel_q.push_back(16'hF800);
    pixel_q.push_back(16'h001F);
    settle();

    // Margin boundary on a full red pixel, then the largest margin
    write_reg(CFG_COLOR_MARGIN, 16'd62);
    pixel_q.push_back(16'hF800);
    settle();
    write_reg(CFG_COLOR_MARGIN, 16'd61);
    pixel_q.push_back(16'hF800);
    settle();
    write_reg(CFG_COLOR_MARGIN, 16'hFFFF);
    pixel_q.push_back(16'h07E0);
    settle();

    // Shrink the frame to exactly one more than the pixels already taken
    write_reg(CFG_COLOR_MARGIN, 16'd0);
    write_reg(CFG_PIXEL_COUNT, 16'd8);
    repeat (4) pixel_q.push_back(16'($urandom));
    settle();
    write_reg(CFG_PIXEL_COUNT, 16'd5);
    pixel_q.push_back(16'($urandom));
    settle();

    // Random phases; partial frames carry over into the next setting
    while (planned < PIXEL_BUDGET) begin
      pace_on  = $urandom_range(0, 3) != 0;
      stall_on = $urandom_range(0, 3) != 0;
      if (phase == 8) begin
        // One largest frame: out-of-range length, then the maximum itself
        write_reg(CFG_COLOR_MARGIN, 16'd1000);
        write_reg(CFG_PIXEL_COUNT, 16'd2047);
        for (int i = 0; i < 1000; i++)
          pixel_q.push_back($urandom_range(0, 1) ? 16'hFFFF : tinted_pixel(TINT_NONE));
        settle();
        write_reg(CFG_PIXEL_COUNT, 16'(FRAME_MAX));
        for (int i = 0; i < FRAME_MAX - 1000; i++) pixel_q.push_back(16'hFFFF);
        planned += FRAME_MAX;
        settle();
      end else begin
        roll = $urandom_range(0, 19);
        if (roll == 0) len = '0;
        else if (roll < 14) len = PIXEL_COUNT_W'($urandom_range(1, 12));
        else len = PIXEL_COUNT_W'($urandom_range(13, 64));
        span = (len == 0) ? 1 : int'(len);
        roll = $urandom_range(0, 9);
        if (roll == 0) marg = '0;
        else if (roll == 1) marg = 16'hFFFF;
        else if (roll == 2) marg = MARGIN_W'($urandom);
        else marg = MARGIN_W'($urandom_range(0, 16 * span));
        // Upper data bits beyond the length field are don't-care
        junk = ($urandom_range(0, 3) == 0) ? 5'($urandom) : 5'd0;
        write_reg(CFG_PIXEL_COUNT, {junk, len});
        write_reg(CFG_COLOR_MARGIN, marg);
        tint = tint_t'($urandom_range(0, 4));
        n = span * $urandom_range(1, 4) + $urandom_range(0, span - 1);
        repeat (n) pixel_q.push_back(tinted_pixel(tint));
        planned += n;
        settle();
      end
      phase++;
    end

    // Drain and let the pipeline run out
    stall_on = 1'b0;
    settle();
    repeat (8) @(posedge clk);

    $display("summary: %0d pixels in %0d phases, %0d frames checked", pixels_taken, phase,
             frames_checked);
    $display("summary: classes black %0d red %0d green %0d blue %0d", class_seen[CLASS_BLACK],
             class_seen[CLASS_RED], class_seen[CLASS_GREEN], class_seen[CLASS_BLUE]);
    if (errors == 0 && expected_frames.size() == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule
